>>> rtl/core/aiou_pkg.sv
// Package with shared constants and types for the 3D box IoU block.
`default_nettype none
package aiou_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned NUM_AXES       = 3;

  typedef struct packed {
    logic valid;
    logic bad;
    logic zero;
    logic full;
  } aiou_ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/aiou_ifs.sv
// Channel interfaces for box-pair requests and IoU responses.
`default_nettype none
interface aiou_req_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] a_min_x, a_min_y, a_min_z;
  logic signed [COORD_BITS-1:0] a_max_x, a_max_y, a_max_z;
  logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_min_z;
  logic signed [COORD_BITS-1:0] b_max_x, b_max_y, b_max_z;

  modport source (output valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
                  b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z, input ready);
  modport sink (input valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
                b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z, output ready);
endinterface

interface aiou_rsp_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] iou;
  logic               bad_box;

  modport source (output valid, iou, bad_box, input ready);
  modport sink (input valid, iou, bad_box, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aiou_geom.sv
// Four-stage geometry pipeline: overlap lengths, volumes and union.
`default_nettype none
module aiou_geom import aiou_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] amin [NUM_AXES],
  input  wire logic signed [COORD_BITS-1:0] amax [NUM_AXES],
  input  wire logic signed [COORD_BITS-1:0] bmin [NUM_AXES],
  input  wire logic signed [COORD_BITS-1:0] bmax [NUM_AXES],
  output aiou_ctl_t                         ctl,
  output logic [3*COORD_BITS-1:0]           ov,
  output logic [3*COORD_BITS:0]             uni
);
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned VW = 3 * CW;

  logic          v1, v2, v3;
  logic          bad1, bad2, bad3;
  logic [CW-1:0] ea1 [NUM_AXES];
  logic [CW-1:0] eb1 [NUM_AXES];
  logic [CW-1:0] eo1 [NUM_AXES];
  logic [CW-1:0] ea_z2, eb_z2, eo_z2;
  logic [2*CW-1:0] pa2, pb2, po2;
  logic [VW-1:0] va3, vb3, vo3;
  logic [CW-1:0] ea_next [NUM_AXES];
  logic [CW-1:0] eb_next [NUM_AXES];
  logic [CW-1:0] eo_next [NUM_AXES];
  logic          bad_next;

  always_comb begin
    logic signed [CW-1:0] lo, hi;
    logic signed [CW:0]   d, da, db;
    bad_next = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      lo = (amin[i] > bmin[i]) ? amin[i] : bmin[i];
      hi = (amax[i] < bmax[i]) ? amax[i] : bmax[i];
      d  = (CW+1)'(hi) - (CW+1)'(lo);
      da = (CW+1)'(amax[i]) - (CW+1)'(amin[i]);
      db = (CW+1)'(bmax[i]) - (CW+1)'(bmin[i]);
      eo_next[i] = (hi > lo) ? d[CW-1:0] : '0;
      ea_next[i] = da[CW-1:0];
      eb_next[i] = db[CW-1:0];
      if ((amin[i] > amax[i]) || (bmin[i] > bmax[i])) begin
        bad_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      ctl.valid <= v3;
    end
    if (en) begin
      ea1   <= ea_next;
      eb1   <= eb_next;
      eo1   <= eo_next;
      bad1  <= bad_next;
      po2   <= eo1[0] * eo1[1];
      pa2   <= ea1[0] * ea1[1];
      pb2   <= eb1[0] * eb1[1];
      eo_z2 <= eo1[2];
      ea_z2 <= ea1[2];
      eb_z2 <= eb1[2];
      bad2  <= bad1;
      vo3   <= po2 * eo_z2;
      va3   <= pa2 * ea_z2;
      vb3   <= pb2 * eb_z2;
      bad3  <= bad2;
      ov    <= vo3;
      uni   <= (VW+1)'(va3) + (VW+1)'(vb3) - (VW+1)'(vo3);
      ctl.bad  <= bad3;
      ctl.zero <= (vo3 == '0);
      ctl.full <= ((VW+1)'(vo3) >= ((VW+1)'(va3) + (VW+1)'(vb3) - (VW+1)'(vo3)));
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/aiou_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
`default_nettype none
module aiou_div import aiou_pkg::*; #(
  parameter int unsigned UW        = 49,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire aiou_ctl_t            in_ctl,
  input  wire logic [UW-1:0]        num,
  input  wire logic [UW-1:0]        den,
  output aiou_ctl_t                 out_ctl,
  output logic [FRAC_BITS-1:0]      quo
);
  aiou_ctl_t            ctl_s [FRAC_BITS+1];
  logic [UW-1:0]        rem_s [FRAC_BITS+1];
  logic [UW-1:0]        den_s [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_s [FRAC_BITS+1];

  assign ctl_s[0] = in_ctl;
  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_stage
    logic [UW:0] t;
    logic        ge;
    assign t  = {rem_s[g], 1'b0};
    assign ge = (t >= {1'b0, den_s[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[g+1].valid <= 1'b0;
      end else if (en) begin
        ctl_s[g+1].valid <= ctl_s[g].valid;
      end
      if (en) begin
        ctl_s[g+1].bad  <= ctl_s[g].bad;
        ctl_s[g+1].zero <= ctl_s[g].zero;
        ctl_s[g+1].full <= ctl_s[g].full;
        rem_s[g+1] <= ge ? UW'(t - {1'b0, den_s[g]}) : t[UW-1:0];
        den_s[g+1] <= den_s[g];
        quo_s[g+1] <= {quo_s[g][FRAC_BITS-2:0], ge};
      end
    end
  end

  assign out_ctl = ctl_s[FRAC_BITS];
  assign quo     = quo_s[FRAC_BITS];
endmodule
`default_nettype wire

>>> rtl/core/aabb_iou_3d.sv
// Top level of the 3D axis-aligned box intersection-over-union pipeline.
// Throughput: one box pair per cycle while the response is not stalled; four geometry
// stages then one divider stage per quotient bit, all advancing together whenever the
// response register is free or taken.
// Reset (synchronous, active high) clears all stage valid bits; no clearing pass.
`default_nettype none
module aabb_iou_3d import aiou_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  aiou_req_if.sink   req,
  aiou_rsp_if.source rsp
);
  localparam int unsigned UW = 3 * COORD_BITS + 1;

  logic                         en;
  logic signed [COORD_BITS-1:0] amin [NUM_AXES];
  logic signed [COORD_BITS-1:0] amax [NUM_AXES];
  logic signed [COORD_BITS-1:0] bmin [NUM_AXES];
  logic signed [COORD_BITS-1:0] bmax [NUM_AXES];
  aiou_ctl_t                    g_ctl, d_ctl;
  logic [3*COORD_BITS-1:0]      ov;
  logic [UW-1:0]                uni;
  logic [FRAC_BITS-1:0]         quo;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign amin = '{req.a_min_x, req.a_min_y, req.a_min_z};
  assign amax = '{req.a_max_x, req.a_max_y, req.a_max_z};
  assign bmin = '{req.b_min_x, req.b_min_y, req.b_min_z};
  assign bmax = '{req.b_max_x, req.b_max_y, req.b_max_z};

  aiou_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk(clk), .rst(rst), .en(en), .in_valid(req.valid),
    .amin(amin), .amax(amax), .bmin(bmin), .bmax(bmax),
    .ctl(g_ctl), .ov(ov), .uni(uni)
  );

  aiou_div #(.UW(UW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_ctl(g_ctl),
    .num({1'b0, ov}), .den(uni), .out_ctl(d_ctl), .quo(quo)
  );

  assign rsp.valid   = d_ctl.valid;
  assign rsp.bad_box = d_ctl.bad;
  always_comb begin
    priority if (d_ctl.bad || d_ctl.zero) begin
      rsp.iou = '0;
    end else if (d_ctl.full) begin
      rsp.iou = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      rsp.iou = {1'b0, quo};
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bad_box |-> rsp.iou == '0)
    else $error("bad box with nonzero iou");
  a_iou_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.iou[FRAC_BITS] |-> rsp.iou[FRAC_BITS-1:0] == '0)
    else $error("iou above one");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken during stall");
endmodule
`default_nettype wire

>>> test/aabb_iou_3d_tb.sv
// Testbench for the 3D box IoU block: random and directed box pairs checked against a predictor.
`default_nettype none
module testbench import aiou_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [CB-1:0] c [12];
  } box_pair_t;

  typedef struct {
    logic [FB:0] iou;
    logic        bad;
  } iou_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aiou_req_if #(.COORD_BITS(CB)) req ();
  aiou_rsp_if #(.FRAC_BITS(FB)) rsp ();

  aabb_iou_3d #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #2 clk = ~clk;

  box_pair_t   pending_pairs[$];
  iou_result_t expected_ious[$];
  int          error_count = 0;
  int          result_count = 0;
  int          bad_count = 0;
  int          full_count = 0;
  int          partial_count = 0;
  bit          hold_sender = 1'b0;
  int          send_wait = 0;
  int          recv_wait = 0;

  function automatic iou_result_t box_iou(box_pair_t p);
    iou_result_t r;
    longint lo, hi;
    longint unsigned ovl, vol_a, vol_b, uni, rem, q;
    longint unsigned len [3];
    r.bad = 1'b0;
    r.iou = '0;
    for (int i = 0; i < 3; i++) begin
      if (p.c[i] > p.c[i+3] || p.c[i+6] > p.c[i+9]) r.bad = 1'b1;
    end
    if (!r.bad) begin
      for (int i = 0; i < 3; i++) begin
        lo = (p.c[i] > p.c[i+6]) ? p.c[i] : p.c[i+6];
        hi = (p.c[i+3] < p.c[i+9]) ? p.c[i+3] : p.c[i+9];
        len[i] = (hi <= lo) ? 0 : longint'(hi - lo);
      end
      ovl = len[0] * len[1] * len[2];
      if (ovl != 0) begin
        vol_a = 1; vol_b = 1;
        for (int i = 0; i < 3; i++) begin
          vol_a = vol_a * longint'(longint'(p.c[i+3]) - longint'(p.c[i]));
          vol_b = vol_b * longint'(longint'(p.c[i+9]) - longint'(p.c[i+6]));
        end
        uni = vol_a + vol_b - ovl;
        if (ovl >= uni) begin
          r.iou = 1 << FB;
        end else begin
          rem = ovl;
          q = 0;
          for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= uni) begin
              rem = rem - uni;
              q = q | 1;
            end
          end
          r.iou = q[FB:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind, span, ext;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 14));
    for (int i = 0; i < 3; i++) begin
      if (kind < 8) begin
        ext = (span == 0) ? 65535 : span;
        p.c[i] = rand_coord(span);
        p.c[i+3] = CB'(int'(p.c[i]) + $urandom_range(0, ext));
        if (p.c[i+3] < p.c[i]) p.c[i+3] = {1'b0, {(CB-1){1'b1}}};
        p.c[i+6] = (kind < 5) ? CB'(int'(p.c[i]) + $urandom_range(0, ext / 2))
                              : rand_coord(span);
        p.c[i+9] = CB'(int'(p.c[i+6]) + $urandom_range(0, ext));
        if (p.c[i+9] < p.c[i+6]) p.c[i+9] = {1'b0, {(CB-1){1'b1}}};
      end else begin
        p.c[i] = rand_coord(span);
        p.c[i+3] = rand_coord(span);
        p.c[i+6] = rand_coord(span);
        p.c[i+9] = rand_coord(span);
      end
    end
    return p;
  endfunction

  function automatic box_pair_t make_pair(int a_lo, int a_hi, int b_lo, int b_hi);
    box_pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.c[i] = CB'(a_lo); p.c[i+3] = CB'(a_hi);
      p.c[i+6] = CB'(b_lo); p.c[i+9] = CB'(b_hi);
    end
    return p;
  endfunction

  initial begin
    box_pair_t p;
    pending_pairs.push_back(make_pair(-32768, 32767, -32768, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, -32767, 32766));
    pending_pairs.push_back(make_pair(-32768, 32767, 0, 1));
    pending_pairs.push_back(make_pair(0, 10, 10, 20));
    pending_pairs.push_back(make_pair(0, 10, 11, 20));
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 0, 10));
    pending_pairs.push_back(make_pair(3, 2, 0, 10));
    pending_pairs.push_back(make_pair(0, 10, 32767, -32768));
    pending_pairs.push_back(make_pair(-1, 1, 0, 2));
    pending_pairs.push_back(make_pair(-32768, -32767, -32768, -32767));
    pending_pairs.push_back(make_pair(0, 3, 1, 2));
    p = make_pair(0, 10, 0, 10);
    p.c[4] = -1;
    pending_pairs.push_back(p);
    p = make_pair(0, 10, 0, 10);
    p.c[9] = 5;
    pending_pairs.push_back(p);
    p = make_pair(0, 10, 5, 15);
    p.c[2] = 11;
    pending_pairs.push_back(p);
    p = make_pair(0, 4, 0, 4);
    p.c[11] = 4 - 16'sd0;
    p.c[5] = 2;
    pending_pairs.push_back(p);
    for (int n = 0; n < 1750; n++) pending_pairs.push_back(random_pair());
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_wait <= 0;
    end else if (req.valid && !req.ready) begin
    end else if (send_wait > 0) begin
      req.valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (!hold_sender && pending_pairs.size() > 0) begin
      box_pair_t p;
      p = pending_pairs.pop_front();
      expected_ious.push_back(box_iou(p));
      {req.a_min_x, req.a_min_y, req.a_min_z} <= {p.c[0], p.c[1], p.c[2]};
      {req.a_max_x, req.a_max_y, req.a_max_z} <= {p.c[3], p.c[4], p.c[5]};
      {req.b_min_x, req.b_min_y, req.b_min_z} <= {p.c[6], p.c[7], p.c[8]};
      {req.b_max_x, req.b_max_y, req.b_max_z} <= {p.c[9], p.c[10], p.c[11]};
      req.valid <= 1'b1;
      send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
    end else begin
      req.valid <= 1'b0;
    end
  end

  initial begin
    {req.a_min_x, req.a_min_y, req.a_min_z, req.a_max_x, req.a_max_y, req.a_max_z} = '0;
    {req.b_min_x, req.b_min_y, req.b_min_z, req.b_max_x, req.b_max_y, req.b_max_z} = '0;
    req.valid = 1'b0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        iou_result_t want;
        int          pause;
        if (expected_ious.size() == 0) begin
          report("unexpected beat", 32'(rsp.iou), 0);
        end else begin
          want = expected_ious.pop_front();
          if (rsp.iou !== want.iou) report("iou", 32'(rsp.iou), 32'(want.iou));
          if (rsp.bad_box !== want.bad) report("bad_box", 32'(rsp.bad_box), 32'(want.bad));
          result_count++;
          if (want.bad) bad_count++;
          else if (want.iou == (1 << FB)) full_count++;
          else if (want.iou != 0) partial_count++;
        end
        pause = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
        recv_wait <= pause;
        rsp.ready <= (pause == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() < 900);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (expected_ious.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;
    wait (pending_pairs.size() == 0 && expected_ious.size() == 0);
    repeat (4 + FB + 20) @(posedge clk);
    $display("Checked %0d box pairs: %0d inverted, %0d full overlap, %0d partial overlap.",
             result_count, bad_count, full_count, partial_count);
    if (error_count == 0) begin
      $display("aabb_iou_3d test passed");
    end else begin
      $display("aabb_iou_3d test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("aabb_iou_3d test failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> aabb_iou_3d.f
rtl/core/aiou_pkg.sv
rtl/core/aiou_ifs.sv
rtl/core/aiou_geom.sv
rtl/core/aiou_div.sv
rtl/core/aabb_iou_3d.sv
test/aabb_iou_3d_tb.sv
